// File: rtl/core/crcp_pkg.sv
// ----------------------------------------------------------------------------
// crcp_pkg
// Shared widths, stage counts and sideband type for the circle/rectangle
// collision pipeline.
// ----------------------------------------------------------------------------
package crcp_pkg;

    localparam int COORD_W = 32;   // signed coordinates
    localparam int SIZE_W  = 31;   // unsigned sizes and diameter
    localparam int RAY_W   = 35;   // signed ray component, exact
    localparam int MAG_W   = 30;   // ray magnitude when the circle can reach
    localparam int SQ_W    = 62;   // squared distance and root work width
    localparam int ROOT_W  = 31;   // integer root of the squared distance
    localparam int SQ_STEPS  = 31; // one root bit per stage
    localparam int DIV_STEPS = 30; // one quotient bit per stage
    localparam int QUO_W     = DIV_STEPS;
    localparam int DEN_W     = ROOT_W + 1;

    typedef struct packed {
        logic                hit;
        logic                in_rect;
        logic                sgn_x;
        logic                sgn_y;
        logic [MAG_W-1:0]    ax;
        logic [MAG_W-1:0]    ay;
        logic [SIZE_W-1:0]   diam;
    } t_side;

endpackage

// File: rtl/core/circle_rect_collision_push.sv
// ----------------------------------------------------------------------------
// circle_rect_collision_push
// Circle versus axis-aligned rectangle test with push-out vector.
// ----------------------------------------------------------------------------
// Usage: drive one circle/rectangle pair on the i_* ports and raise start for
// one cycle. The block never pushes back, so busy is always low and a new word
// may be started in every clock cycle.
// Each started word produces exactly one result word, shown on o_hit,
// o_push_x, o_push_y and o_centre_inside for a single cycle while o_valid is
// high. Results leave in the order in which words were started.
// Throughput is one word per cycle. The pipeline depth is mostly set by the root
// extraction (31 stages, one root bit per stage) and the two push dividers
// (30 stages, one quotient bit per stage, running side by side).
// The receiver cannot stall: every result is valid for exactly one cycle.
// A synchronous active-low reset clears all valid bits, so words in flight
// are dropped and no result appears until new words are started.
// A centre inside or on the rectangle border reports a hit with zero push and
// o_centre_inside set. Without a hit all result fields are zero.
// ----------------------------------------------------------------------------
module circle_rect_collision_push
    import crcp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_circle_x,
    input  logic signed [COORD_W-1:0] i_circle_y,
    input  logic        [SIZE_W-1:0]  i_circle_diameter,
    input  logic signed [COORD_W-1:0] i_rect_pos_x,
    input  logic signed [COORD_W-1:0] i_rect_pos_y,
    input  logic signed [COORD_W-1:0] i_rect_origin_x,
    input  logic signed [COORD_W-1:0] i_rect_origin_y,
    input  logic        [SIZE_W-1:0]  i_rect_width,
    input  logic        [SIZE_W-1:0]  i_rect_height,
    output logic                      o_valid,
    output logic                      o_hit,
    output logic signed [COORD_W-1:0] o_push_x,
    output logic signed [COORD_W-1:0] o_push_y,
    output logic                      o_centre_inside
);

    // The pipeline never stalls.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage A: capture the input word.
    // ------------------------------------------------------------------
    logic                      r_a_vld;
    logic signed [COORD_W-1:0] r_a_cx, r_a_cy, r_a_px, r_a_py, r_a_ox, r_a_oy;
    logic        [SIZE_W-1:0]  r_a_diam, r_a_w, r_a_h;

    always_ff @(posedge i_clk) begin
        r_a_cx   <= i_circle_x;
        r_a_cy   <= i_circle_y;
        r_a_diam <= i_circle_diameter;
        r_a_px   <= i_rect_pos_x;
        r_a_py   <= i_rect_pos_y;
        r_a_ox   <= i_rect_origin_x;
        r_a_oy   <= i_rect_origin_y;
        r_a_w    <= i_rect_width;
        r_a_h    <= i_rect_height;
    end

    // ------------------------------------------------------------------
    // Stage B: rectangle corners, exact in RAY_W bits.
    // ------------------------------------------------------------------
    logic                    r_b_vld;
    logic signed [RAY_W-1:0] r_b_tlx, r_b_tly, r_b_brx, r_b_bry, r_b_cx, r_b_cy;
    logic        [SIZE_W-1:0] r_b_diam;
    logic signed [RAY_W-1:0] n_b_tlx, n_b_tly;

    always_comb begin
        n_b_tlx = RAY_W'(r_a_px) - RAY_W'(r_a_ox);
        n_b_tly = RAY_W'(r_a_py) - RAY_W'(r_a_oy);
    end

    always_ff @(posedge i_clk) begin
        r_b_tlx  <= n_b_tlx;
        r_b_tly  <= n_b_tly;
        r_b_brx  <= n_b_tlx + $signed({{(RAY_W-SIZE_W){1'b0}}, r_a_w});
        r_b_bry  <= n_b_tly + $signed({{(RAY_W-SIZE_W){1'b0}}, r_a_h});
        r_b_cx   <= RAY_W'(r_a_cx);
        r_b_cy   <= RAY_W'(r_a_cy);
        r_b_diam <= r_a_diam;
    end

    // ------------------------------------------------------------------
    // Stage C: clamp the centre into the rectangle and form the ray.
    // ------------------------------------------------------------------
    logic                    r_c_vld;
    logic signed [RAY_W-1:0] r_c_rx, r_c_ry;
    logic        [SIZE_W-1:0] r_c_diam;
    logic signed [RAY_W-1:0] n_c_mx, n_c_my, n_c_kx, n_c_ky;

    always_comb begin
        n_c_mx = (r_b_tlx > r_b_cx) ? r_b_tlx : r_b_cx;
        n_c_my = (r_b_tly > r_b_cy) ? r_b_tly : r_b_cy;
        n_c_kx = (r_b_brx < n_c_mx) ? r_b_brx : n_c_mx;
        n_c_ky = (r_b_bry < n_c_my) ? r_b_bry : n_c_my;
    end

    always_ff @(posedge i_clk) begin
        r_c_rx   <= n_c_kx - r_b_cx;
        r_c_ry   <= n_c_ky - r_b_cy;
        r_c_diam <= r_b_diam;
    end

    // ------------------------------------------------------------------
    // Stage D: magnitudes, inside flag and the per-axis reach test.
    // ------------------------------------------------------------------
    logic              r_d_vld, r_d_inside, r_d_near, r_d_sx, r_d_sy;
    logic [MAG_W-1:0]  r_d_ax, r_d_ay;
    logic [SIZE_W-1:0] r_d_diam;
    logic [RAY_W-1:0]  n_d_mx, n_d_my;

    always_comb begin
        n_d_mx = r_c_rx[RAY_W-1] ? RAY_W'(-r_c_rx) : RAY_W'(r_c_rx);
        n_d_my = r_c_ry[RAY_W-1] ? RAY_W'(-r_c_ry) : RAY_W'(r_c_ry);
    end

    always_ff @(posedge i_clk) begin
        r_d_inside <= (r_c_rx == '0) && (r_c_ry == '0);
        r_d_near   <= ({n_d_mx, 1'b0} <= (RAY_W+1)'(r_c_diam))
                   && ({n_d_my, 1'b0} <= (RAY_W+1)'(r_c_diam));
        r_d_sx     <= r_c_rx[RAY_W-1];
        r_d_sy     <= r_c_ry[RAY_W-1];
        r_d_ax     <= n_d_mx[MAG_W-1:0];
        r_d_ay     <= n_d_my[MAG_W-1:0];
        r_d_diam   <= r_c_diam;
    end

    // ------------------------------------------------------------------
    // Stage E: squares of the ray components and of the diameter.
    // ------------------------------------------------------------------
    logic                  r_e_vld, r_e_inside, r_e_near, r_e_sx, r_e_sy;
    logic [MAG_W-1:0]      r_e_ax, r_e_ay;
    logic [SIZE_W-1:0]     r_e_diam;
    logic [2*MAG_W-1:0]    r_e_sqx, r_e_sqy;
    logic [2*SIZE_W-1:0]   r_e_dd;

    always_ff @(posedge i_clk) begin
        r_e_sqx    <= (2*MAG_W)'(r_d_ax) * (2*MAG_W)'(r_d_ax);
        r_e_sqy    <= (2*MAG_W)'(r_d_ay) * (2*MAG_W)'(r_d_ay);
        r_e_dd     <= (2*SIZE_W)'(r_d_diam) * (2*SIZE_W)'(r_d_diam);
        r_e_inside <= r_d_inside;
        r_e_near   <= r_d_near;
        r_e_sx     <= r_d_sx;
        r_e_sy     <= r_d_sy;
        r_e_ax     <= r_d_ax;
        r_e_ay     <= r_d_ay;
        r_e_diam   <= r_d_diam;
    end

    // ------------------------------------------------------------------
    // Stage F: squared distance and the exact hit test 4*d^2 <= diam^2.
    // This stage loads the first root stage.
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] n_f_dsq;
    logic            n_f_hit;

    always_comb begin
        n_f_dsq = SQ_W'(r_e_sqx) + SQ_W'(r_e_sqy);
        n_f_hit = r_e_inside
               || (r_e_near && ({n_f_dsq, 2'b00} <= (SQ_W+2)'(r_e_dd)));
    end

    // Root extraction: one result bit per stage, test bit falling by four.
    logic [SQ_STEPS:0]            r_sq_vld;
    logic [SQ_W-1:0]              r_sq_rem [SQ_STEPS+1];
    logic [SQ_W-1:0]              r_sq_res [SQ_STEPS+1];
    t_side                        r_sq_side[SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        r_sq_rem[0]          <= n_f_dsq;
        r_sq_res[0]          <= '0;
        r_sq_side[0].hit     <= n_f_hit;
        r_sq_side[0].in_rect <= r_e_inside;
        r_sq_side[0].sgn_x   <= r_e_sx;
        r_sq_side[0].sgn_y   <= r_e_sy;
        r_sq_side[0].ax      <= r_e_ax;
        r_sq_side[0].ay      <= r_e_ay;
        r_sq_side[0].diam    <= r_e_diam;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2*(SQ_STEPS-1-k));
        logic [SQ_W-1:0] n_trial;
        assign n_trial = r_sq_res[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (r_sq_rem[k] >= n_trial) begin
                r_sq_rem[k+1] <= r_sq_rem[k] - n_trial;
                r_sq_res[k+1] <= (r_sq_res[k] >> 1) + BIT;
            end else begin
                r_sq_rem[k+1] <= r_sq_rem[k];
                r_sq_res[k+1] <= r_sq_res[k] >> 1;
            end
            r_sq_side[k+1] <= r_sq_side[k];
        end
    end

    // ------------------------------------------------------------------
    // Stage G: gap = diam - 2*dist and divisor 2*dist.
    // ------------------------------------------------------------------
    logic              r_g_vld;
    logic [SIZE_W-1:0] r_g_gap;
    logic [DEN_W-1:0]  r_g_den;
    t_side             r_g_side;
    logic [ROOT_W-1:0] n_g_dist;

    assign n_g_dist = r_sq_res[SQ_STEPS][ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        r_g_gap  <= r_sq_side[SQ_STEPS].diam - SIZE_W'({n_g_dist, 1'b0});
        r_g_den  <= {n_g_dist, 1'b0};
        r_g_side <= r_sq_side[SQ_STEPS];
    end

    // ------------------------------------------------------------------
    // Stage H: numerators |r| * gap, loading the first divider stage.
    // Dividers: restoring, one quotient bit per stage, x and y side by side.
    // ------------------------------------------------------------------
    logic [DIV_STEPS:0]  r_dv_vld;
    logic [SQ_W-1:0]     r_dv_nx [DIV_STEPS+1];
    logic [SQ_W-1:0]     r_dv_ny [DIV_STEPS+1];
    logic [QUO_W-1:0]    r_dv_qx [DIV_STEPS+1];
    logic [QUO_W-1:0]    r_dv_qy [DIV_STEPS+1];
    logic [DEN_W-1:0]    r_dv_den[DIV_STEPS+1];
    t_side               r_dv_side[DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        r_dv_nx[0]   <= SQ_W'(r_g_side.ax) * SQ_W'(r_g_gap);
        r_dv_ny[0]   <= SQ_W'(r_g_side.ay) * SQ_W'(r_g_gap);
        r_dv_qx[0]   <= '0;
        r_dv_qy[0]   <= '0;
        r_dv_den[0]  <= r_g_den;
        r_dv_side[0] <= r_g_side;
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int SH = DIV_STEPS - 1 - j;
        logic [SQ_W-1:0] n_dsh;
        assign n_dsh = SQ_W'(r_dv_den[j]) << SH;
        always_ff @(posedge i_clk) begin
            if (r_dv_nx[j] >= n_dsh) begin
                r_dv_nx[j+1] <= r_dv_nx[j] - n_dsh;
                r_dv_qx[j+1] <= r_dv_qx[j] | (QUO_W'(1) << SH);
            end else begin
                r_dv_nx[j+1] <= r_dv_nx[j];
                r_dv_qx[j+1] <= r_dv_qx[j];
            end
            if (r_dv_ny[j] >= n_dsh) begin
                r_dv_ny[j+1] <= r_dv_ny[j] - n_dsh;
                r_dv_qy[j+1] <= r_dv_qy[j] | (QUO_W'(1) << SH);
            end else begin
                r_dv_ny[j+1] <= r_dv_ny[j];
                r_dv_qy[j+1] <= r_dv_qy[j];
            end
            r_dv_den[j+1]  <= r_dv_den[j];
            r_dv_side[j+1] <= r_dv_side[j];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sign the quotients and zero the push unless it applies.
    // The quotient never exceeds half the gap, so no saturation is needed.
    // ------------------------------------------------------------------
    t_side                     n_o_side;
    logic                      n_o_push;
    logic signed [COORD_W-1:0] n_o_qx, n_o_qy;

    always_comb begin
        n_o_side = r_dv_side[DIV_STEPS];
        n_o_push = n_o_side.hit && !n_o_side.in_rect;
        n_o_qx   = $signed(COORD_W'(r_dv_qx[DIV_STEPS]));
        n_o_qy   = $signed(COORD_W'(r_dv_qy[DIV_STEPS]));
    end

    always_ff @(posedge i_clk) begin
        o_hit           <= n_o_side.hit;
        o_centre_inside <= n_o_side.in_rect;
        o_push_x        <= !n_o_push ? '0 : (n_o_side.sgn_x ? -n_o_qx : n_o_qx);
        o_push_y        <= !n_o_push ? '0 : (n_o_side.sgn_y ? -n_o_qy : n_o_qy);
    end

    // ------------------------------------------------------------------
    // Valid bits travel alongside the data and are the only reset state.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_c_vld  <= 1'b0;
            r_d_vld  <= 1'b0;
            r_e_vld  <= 1'b0;
            r_sq_vld <= '0;
            r_g_vld  <= 1'b0;
            r_dv_vld <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_a_vld  <= start;
            r_b_vld  <= r_a_vld;
            r_c_vld  <= r_b_vld;
            r_d_vld  <= r_c_vld;
            r_e_vld  <= r_d_vld;
            r_sq_vld <= {r_sq_vld[SQ_STEPS-1:0], r_e_vld};
            r_g_vld  <= r_sq_vld[SQ_STEPS];
            r_dv_vld <= {r_dv_vld[DIV_STEPS-1:0], r_g_vld};
            o_valid  <= r_dv_vld[DIV_STEPS];
        end
    end

endmodule

// File: sim/circle_rect_collision_push_checker.sv
// ----------------------------------------------------------------------------
// circle_rect_collision_push_checker
// Watches the start and result channels of the collision block, predicts each
// result word from the accepted inputs, and compares every field in order.
// ----------------------------------------------------------------------------
module circle_rect_collision_push_checker
    import crcp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic signed [COORD_W-1:0] i_circle_x,
    input  logic signed [COORD_W-1:0] i_circle_y,
    input  logic        [SIZE_W-1:0]  i_circle_diameter,
    input  logic signed [COORD_W-1:0] i_rect_pos_x,
    input  logic signed [COORD_W-1:0] i_rect_pos_y,
    input  logic signed [COORD_W-1:0] i_rect_origin_x,
    input  logic signed [COORD_W-1:0] i_rect_origin_y,
    input  logic        [SIZE_W-1:0]  i_rect_width,
    input  logic        [SIZE_W-1:0]  i_rect_height,
    input  logic                      i_valid,
    input  logic                      i_hit,
    input  logic signed [COORD_W-1:0] i_push_x,
    input  logic signed [COORD_W-1:0] i_push_y,
    input  logic                      i_centre_inside,
    output int                        o_errors,
    output int                        o_pending
);

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] push_x;
        logic signed [COORD_W-1:0] push_y;
        logic                      in_rect;
    } t_push_word;

    t_push_word expected_pushes[$];

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned magnitude(longint r);
        return (r < 0) ? longint'(-r) : longint'(r);
    endfunction

    // Component of the push vector, rounded toward zero and clipped to 32 bits.
    function automatic logic [COORD_W-1:0] push_component(longint r, longint unsigned num,
                                                          longint unsigned den);
        longint unsigned q;
        q = (magnitude(r) * num) / den;
        if (r < 0) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return COORD_W'(-longint'(q));
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return COORD_W'(q);
    endfunction

    function automatic t_push_word predict_push();
        t_push_word      w;
        longint          tlx, tly, brx, bry, cx, cy, rx, ry, clx, cly;
        longint unsigned diam, ax, ay, dsq, root_dist;
        w    = '0;
        cx   = longint'(i_circle_x);
        cy   = longint'(i_circle_y);
        diam = longint'(i_circle_diameter);
        tlx  = longint'(i_rect_pos_x) - longint'(i_rect_origin_x);
        tly  = longint'(i_rect_pos_y) - longint'(i_rect_origin_y);
        brx  = tlx + longint'(i_rect_width);
        bry  = tly + longint'(i_rect_height);
        clx  = (cx < tlx) ? tlx : cx;
        clx  = (clx > brx) ? brx : clx;
        cly  = (cy < tly) ? tly : cy;
        cly  = (cly > bry) ? bry : cly;
        rx   = clx - cx;
        ry   = cly - cy;
        ax   = magnitude(rx);
        ay   = magnitude(ry);
        if (rx == 0 && ry == 0) begin
            w.hit     = 1'b1;
            w.in_rect = 1'b1;
        end else if (2 * ax <= diam && 2 * ay <= diam) begin
            dsq = ax * ax + ay * ay;
            if (4 * dsq <= diam * diam) begin
                root_dist = floor_root(dsq);
                w.hit     = 1'b1;
                w.push_x  = push_component(rx, diam - 2 * root_dist, 2 * root_dist);
                w.push_y  = push_component(ry, diam - 2 * root_dist, 2 * root_dist);
            end
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_push_word exp_w;
        if (i_rst_n && i_start && !i_busy)
            expected_pushes.push_back(predict_push());
        if (i_rst_n && i_valid) begin
            if (expected_pushes.size() == 0) begin
                $display("%0t: result word with none expected: hit %0d push %0d,%0d inside %0d",
                         $time, i_hit, i_push_x, i_push_y, i_centre_inside);
                o_errors <= o_errors + 1;
            end else begin
                exp_w = expected_pushes.pop_front();
                if (exp_w.hit !== i_hit || exp_w.push_x !== i_push_x ||
                    exp_w.push_y !== i_push_y || exp_w.in_rect !== i_centre_inside) begin
                    $display("%0t: mismatch expected hit %0d push %0d,%0d inside %0d",
                             $time, exp_w.hit, exp_w.push_x, exp_w.push_y, exp_w.in_rect);
                    $display("%0t:          actual   hit %0d push %0d,%0d inside %0d",
                             $time, i_hit, i_push_x, i_push_y, i_centre_inside);
                    o_errors <= o_errors + 1;
                end
            end
        end
        o_pending <= expected_pushes.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

endmodule

// File: sim/circle_rect_collision_push_test.sv
// ----------------------------------------------------------------------------
// circle_rect_collision_push_test
// Drives circle/rectangle pairs into the collision block and gives the verdict.
// ----------------------------------------------------------------------------
// A directed set covers the range extremes, a centre inside and on the border,
// an exact touch, zero diameter and empty rectangles. The random part mostly
// places circles near small rectangles so that hits and corner cases are
// common, and mixes in full-range noise so that every input bit toggles.
// A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module circle_rect_collision_push_test;
    import crcp_pkg::*;

    localparam int RANDOM_WORDS  = 1330;
    localparam int STEADY_WORDS  = 200;   // final stretch without idle gaps
    localparam int DRAIN_CYCLES  = 80;    // a little over the pipeline latency
    localparam int ONE           = 1 << 16;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] i_circle_x, i_circle_y;
    logic        [SIZE_W-1:0]  i_circle_diameter;
    logic signed [COORD_W-1:0] i_rect_pos_x, i_rect_pos_y;
    logic signed [COORD_W-1:0] i_rect_origin_x, i_rect_origin_y;
    logic        [SIZE_W-1:0]  i_rect_width, i_rect_height;
    logic                      o_valid, o_hit, o_centre_inside;
    logic signed [COORD_W-1:0] o_push_x, o_push_y;
    int                        error_count;
    int                        pending_words;

    circle_rect_collision_push uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_circle_x(i_circle_x), .i_circle_y(i_circle_y),
        .i_circle_diameter(i_circle_diameter),
        .i_rect_pos_x(i_rect_pos_x), .i_rect_pos_y(i_rect_pos_y),
        .i_rect_origin_x(i_rect_origin_x), .i_rect_origin_y(i_rect_origin_y),
        .i_rect_width(i_rect_width), .i_rect_height(i_rect_height),
        .o_valid(o_valid), .o_hit(o_hit), .o_push_x(o_push_x), .o_push_y(o_push_y),
        .o_centre_inside(o_centre_inside)
    );

    circle_rect_collision_push_checker push_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_circle_x(i_circle_x), .i_circle_y(i_circle_y),
        .i_circle_diameter(i_circle_diameter),
        .i_rect_pos_x(i_rect_pos_x), .i_rect_pos_y(i_rect_pos_y),
        .i_rect_origin_x(i_rect_origin_x), .i_rect_origin_y(i_rect_origin_y),
        .i_rect_width(i_rect_width), .i_rect_height(i_rect_height),
        .i_valid(o_valid), .i_hit(o_hit), .i_push_x(o_push_x), .i_push_y(o_push_y),
        .i_centre_inside(o_centre_inside),
        .o_errors(error_count), .o_pending(pending_words)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Places one word on the ports and holds it until the block takes it.
    // Busy only moves on a rising edge, so its value at the falling edge is
    // the value the next rising edge sees. Sizes arrive as 32-bit values and
    // only their low 31 bits are driven.
    task automatic send_pair(logic [31:0] cx, logic [31:0] cy, logic [31:0] diam,
                             logic [31:0] px, logic [31:0] py,
                             logic [31:0] ox, logic [31:0] oy,
                             logic [31:0] w, logic [31:0] h);
        i_circle_x        <= cx;
        i_circle_y        <= cy;
        i_circle_diameter <= diam[SIZE_W-1:0];
        i_rect_pos_x      <= px;
        i_rect_pos_y      <= py;
        i_rect_origin_x   <= ox;
        i_rect_origin_y   <= oy;
        i_rect_width      <= w[SIZE_W-1:0];
        i_rect_height     <= h[SIZE_W-1:0];
        start             <= 1'b1;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(7, 1);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // A pair close to a small rectangle, so the circle often reaches it.
    task automatic send_near_pair(bit big);
        longint tlx, tly, w, h, d, cx, cy;
        w   = big ? $urandom_range(32'h7FFF_FFFF, 0) : $urandom_range(8 * ONE, 0);
        h   = big ? $urandom_range(32'h7FFF_FFFF, 0) : $urandom_range(8 * ONE, 0);
        d   = big ? $urandom_range(32'h7FFF_FFFF, 0) : $urandom_range(6 * ONE, 0);
        tlx = longint'($signed($urandom())) >>> $urandom_range(14, 0);
        tly = longint'($signed($urandom())) >>> $urandom_range(14, 0);
        cx  = tlx - d + longint'($urandom_range(32'(w + 2 * d), 0));
        cy  = tly - d + longint'($urandom_range(32'(h + 2 * d), 0));
        if ($urandom_range(3, 0) == 0) cx = tlx + ($urandom_range(1, 0) ? w : 0);
        send_pair(32'(cx), 32'(cy), 32'(d), 32'(tlx + 5 * ONE), 32'(tly),
                  32'(5 * ONE), 32'(0), 32'(w), 32'(h));
    endtask

    initial begin
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_circle_x        = '0;
        i_circle_y        = '0;
        i_circle_diameter = '0;
        i_rect_pos_x      = '0;
        i_rect_pos_y      = '0;
        i_rect_origin_x   = '0;
        i_rect_origin_y   = '0;
        i_rect_width      = '0;
        i_rect_height     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words.
        // Centre inside, then on the border, then at a corner.
        send_pair(0, 0, 4 * ONE, 0, 0, ONE, ONE, 2 * ONE, 2 * ONE);
        send_pair(ONE, 0, 4 * ONE, 0, 0, 0, 0, ONE, ONE);
        send_pair(ONE, ONE, 0, 0, 0, 0, 0, ONE, ONE);
        // Zero diameter inside and just outside.
        send_pair(ONE / 2, ONE / 2, 0, 0, 0, 0, 0, ONE, ONE);
        send_pair(ONE + 1, 0, 0, 0, 0, 0, 0, ONE, ONE);
        // Exact touch along one axis, one unit beyond it, and a diagonal.
        send_pair(-3 * ONE, 0, 6 * ONE, 0, 0, 0, 0, ONE, ONE);
        send_pair(-3 * ONE - 1, 0, 6 * ONE, 0, 0, 0, 0, ONE, ONE);
        send_pair(-3 * ONE, -4 * ONE, 10 * ONE, 0, 0, 0, 0, ONE, ONE);
        send_pair(-1, -1, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        // Empty rectangle, a point.
        send_pair(ONE, ONE, 3 * ONE, 0, 0, 0, 0, 0, 0);
        // Range extremes, far apart and overlapping.
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                  0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'h4000_0000, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        send_pair(32'hC000_0001, 32'h0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        send_pair(-5, 7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(2 * ONE, -2, 5, 0, 0, -ONE, 0, ONE, ONE);

        // Random words: mostly near pairs, some full-range noise.
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k < RANDOM_WORDS - STEADY_WORDS && $urandom_range(3, 0) == 0)
                idle_gap();
            case ($urandom_range(9, 0))
                0: send_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom(), $urandom());
                1: send_near_pair(1'b1);
                default: send_near_pair(1'b0);
            endcase
        end
        start <= 1'b0;

        while (pending_words != 0 || start) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_words == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Generous limit on the simulation time.
    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule
